[sv/vehc_pkg.sv]
// Package with shared constants, codes and types of the variable-edge histogram counter.
`timescale 1ns / 1ps

package vehc_pkg;

  // Bin count is a power of two, so counter addresses are {group, bin}.
  localparam int unsigned NUM_BINS    = 16;
  localparam int unsigned NUM_EDGES   = NUM_BINS + 1;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned BIN_W       = $clog2(NUM_BINS);
  localparam int unsigned EIDX_W      = 5;
  localparam int unsigned TGT_W       = 3;
  localparam int unsigned RC_W        = 4;

  localparam int unsigned NUM_TARGETS = 8;
  localparam int unsigned NUM_SIDELOC = 4;
  localparam int unsigned NUM_SIDES   = 2;

  localparam int unsigned TGT_DEPTH  = NUM_TARGETS * NUM_BINS;
  localparam int unsigned SL_DEPTH   = NUM_SIDELOC * NUM_BINS;
  localparam int unsigned SIDE_DEPTH = NUM_SIDES * NUM_BINS;
  localparam int unsigned CLR_W      = $clog2(TGT_DEPTH);

  // Counter selector ranges of a read request.
  localparam logic [RC_W-1:0] RC_SL_BASE   = RC_W'(NUM_TARGETS);
  localparam logic [RC_W-1:0] RC_SIDE_BASE = RC_W'(NUM_TARGETS + NUM_SIDELOC);
  localparam logic [RC_W-1:0] RC_END       = RC_W'(NUM_TARGETS + NUM_SIDELOC + NUM_SIDES);

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_COUNT = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BELOW = 2'd1,
    STAT_ABOVE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic             below;
    logic             above;
    logic [BIN_W-1:0] bin;
  } lookup_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH-1:0] r;
    if (&v) begin
      r = v;
    end else begin
      r = v + COUNT_WIDTH'(1);
    end
    return r;
  endfunction

endpackage

[sv/vehc_edge_bank.sv]
// The up and down edge sets in flip-flops, with a parallel compare and priority encode of a sample.
`timescale 1ns / 1ps

module vehc_edge_bank (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    we_i,
  input  logic                                    wr_set_i,
  input  logic [vehc_pkg::EIDX_W-1:0]             wr_idx_i,
  input  logic signed [vehc_pkg::VALUE_WIDTH-1:0] wr_value_i,
  input  logic                                    rd_set_i,
  input  logic signed [vehc_pkg::VALUE_WIDTH-1:0] sample_i,
  output vehc_pkg::lookup_t                       result_o
);

  logic signed [vehc_pkg::VALUE_WIDTH-1:0] up_q [vehc_pkg::NUM_EDGES];
  logic signed [vehc_pkg::VALUE_WIDTH-1:0] dn_q [vehc_pkg::NUM_EDGES];
  logic [vehc_pkg::NUM_EDGES-1:0]          le;
  logic [vehc_pkg::EIDX_W-1:0]             first_idx;
  logic                                    lt_first;
  logic                                    wr_ok;

  assign wr_ok = we_i && ({1'b0, wr_idx_i} <= (vehc_pkg::EIDX_W + 1)'(vehc_pkg::NUM_BINS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < vehc_pkg::NUM_EDGES; i++) begin
        up_q[i] <= '0;
        dn_q[i] <= '0;
      end
    end else if (wr_ok) begin
      if (wr_set_i) begin
        dn_q[wr_idx_i] <= wr_value_i;
      end else begin
        up_q[wr_idx_i] <= wr_value_i;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < vehc_pkg::NUM_EDGES; i++) begin
      le[i] = rd_set_i ? (sample_i <= dn_q[i]) : (sample_i <= up_q[i]);
    end
    lt_first = rd_set_i ? (sample_i < dn_q[0]) : (sample_i < up_q[0]);
  end

  // The lowest edge not below the sample wins.
  always_comb begin
    first_idx = '0;
    for (int i = vehc_pkg::NUM_EDGES - 1; i >= 0; i--) begin
      if (le[i]) begin
        first_idx = vehc_pkg::EIDX_W'(i);
      end
    end
  end

  always_comb begin
    result_o.above = ~|le;
    result_o.below = lt_first;
    if (first_idx == '0) begin
      result_o.bin = '0;
    end else begin
      result_o.bin = vehc_pkg::BIN_W'(first_idx - vehc_pkg::EIDX_W'(1));
    end
  end

endmodule

[sv/vehc_count_ram.sv]
// Single-port-write, registered-read counter memory.
`timescale 1ns / 1ps

module vehc_count_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/variable_edge_histogram_counter.sv]
// Top level of the variable-edge histogram counter with its request sequencer.
`timescale 1ns / 1ps

// Histogram with two programmable edge sets and three banks of saturating
// counters held in synchronous memories. Every accepted word gives exactly one
// result word. A word passes through two states: lookup compares the sample
// against all edges of its set in parallel and issues the counter reads,
// update increments the counters hit by a count and writes them back
// through the single write port of each memory. Input is accepted again in the
// cycle that the previous word finishes, so a new word is not taken before the
// previous one is done; a result waiting at the output register does not block
// the next word until that word reaches write-back. After reset a clearing
// pass zeroes the counter memories, during which in_stall_o stays high.
module variable_edge_histogram_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic        edge_set_i,
  input  logic [4:0]  edge_index_i,
  input  logic signed [31:0] edge_value_i,
  input  logic signed [31:0] sample_value_i,
  input  logic [2:0]  target_i,
  input  logic [3:0]  read_counter_i,
  input  logic [3:0]  read_bin_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  bin_index_o,
  output logic [31:0] count_value_o
);

  localparam int unsigned TAW = $clog2(vehc_pkg::TGT_DEPTH);
  localparam int unsigned SAW = $clog2(vehc_pkg::SL_DEPTH);
  localparam int unsigned DAW = $clog2(vehc_pkg::SIDE_DEPTH);
  localparam int unsigned CW  = vehc_pkg::COUNT_WIDTH;

  vehc_pkg::state_e state_q, state_d;
  logic [vehc_pkg::CLR_W-1:0] clr_q, clr_d;

  // Captured request word.
  vehc_pkg::req_e                          req_q;
  logic                                    set_q;
  logic [vehc_pkg::EIDX_W-1:0]             eidx_q;
  logic signed [vehc_pkg::VALUE_WIDTH-1:0] evalue_q;
  logic signed [vehc_pkg::VALUE_WIDTH-1:0] sample_q;
  logic [vehc_pkg::TGT_W-1:0]              tgt_q;
  logic [vehc_pkg::RC_W-1:0]               rc_q;
  logic [vehc_pkg::BIN_W-1:0]              rb_q;

  vehc_pkg::lookup_t lk, lk_q;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q, status_d;
  logic [3:0]  bin_q, bin_d;
  logic [31:0] count_q, count_d;

  logic in_accept;
  logic done;
  logic edge_we;
  logic mem_re;
  logic clr_we;
  logic cnt_we;
  logic hit;

  logic [TAW-1:0] t_raddr, t_waddr;
  logic [SAW-1:0] s_raddr, s_waddr;
  logic [DAW-1:0] d_raddr, d_waddr;
  logic [CW-1:0]  t_rdata, s_rdata, d_rdata;
  logic [CW-1:0]  t_wdata, s_wdata, d_wdata;
  logic [CW-1:0]  rd_value;

  assign in_accept = in_valid_i && !in_stall_o;
  assign done      = !out_valid_q || !out_stall_i;
  assign hit       = !lk_q.below && !lk_q.above;

  // Next state.
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      vehc_pkg::ST_CLEAR: begin
        clr_d = clr_q + vehc_pkg::CLR_W'(1);
        if (&clr_q) begin
          state_d = vehc_pkg::ST_IDLE;
        end
      end
      vehc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = vehc_pkg::ST_LOOKUP;
        end
      end
      vehc_pkg::ST_LOOKUP: begin
        state_d = vehc_pkg::ST_UPDATE;
      end
      vehc_pkg::ST_UPDATE: begin
        if (done) begin
          state_d = in_valid_i ? vehc_pkg::ST_LOOKUP : vehc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vehc_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    edge_we    = 1'b0;
    mem_re     = 1'b0;
    clr_we     = 1'b0;
    cnt_we     = 1'b0;
    unique case (state_q)
      vehc_pkg::ST_CLEAR: begin
        clr_we = 1'b1;
      end
      vehc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      vehc_pkg::ST_LOOKUP: begin
        edge_we = (req_q == vehc_pkg::REQ_LOAD);
        mem_re  = 1'b1;
      end
      vehc_pkg::ST_UPDATE: begin
        in_stall_o = !done;
        cnt_we     = done && (req_q == vehc_pkg::REQ_COUNT) && hit;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vehc_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q    <= vehc_pkg::req_e'(req_type_i);
      set_q    <= edge_set_i;
      eidx_q   <= edge_index_i;
      evalue_q <= edge_value_i;
      sample_q <= sample_value_i;
      tgt_q    <= target_i;
      rc_q     <= read_counter_i;
      rb_q     <= read_bin_i;
    end
    if (state_q == vehc_pkg::ST_LOOKUP) begin
      lk_q <= lk;
    end
    if (state_q == vehc_pkg::ST_UPDATE && done) begin
      status_q <= status_d;
      bin_q    <= bin_d;
      count_q  <= count_d;
    end
  end

  vehc_edge_bank u_edges (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (edge_we),
    .wr_set_i   (set_q),
    .wr_idx_i   (eidx_q),
    .wr_value_i (evalue_q),
    .rd_set_i   (set_q),
    .sample_i   (sample_q),
    .result_o   (lk)
  );

  // Read addresses: a read request names its counter, a count uses the found bin.
  always_comb begin
    if (req_q == vehc_pkg::REQ_READ) begin
      t_raddr = {rc_q[2:0], rb_q};
      s_raddr = {rc_q[1:0], rb_q};
      d_raddr = {rc_q[0], rb_q};
    end else begin
      t_raddr = {tgt_q, lk.bin};
      s_raddr = {tgt_q[2:1], lk.bin};
      d_raddr = {tgt_q[2], lk.bin};
    end
  end

  always_comb begin
    if (clr_we) begin
      t_waddr = clr_q[TAW-1:0];
      s_waddr = clr_q[SAW-1:0];
      d_waddr = clr_q[DAW-1:0];
      t_wdata = '0;
      s_wdata = '0;
      d_wdata = '0;
    end else begin
      t_waddr = {tgt_q, lk_q.bin};
      s_waddr = {tgt_q[2:1], lk_q.bin};
      d_waddr = {tgt_q[2], lk_q.bin};
      t_wdata = vehc_pkg::sat_inc(t_rdata);
      s_wdata = vehc_pkg::sat_inc(s_rdata);
      d_wdata = vehc_pkg::sat_inc(d_rdata);
    end
  end

  vehc_count_ram #(.DEPTH(vehc_pkg::TGT_DEPTH), .WIDTH(CW)) u_tgt_ram (
    .clk_i   (clk_i),
    .we_i    (clr_we || cnt_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (mem_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  vehc_count_ram #(.DEPTH(vehc_pkg::SL_DEPTH), .WIDTH(CW)) u_sl_ram (
    .clk_i   (clk_i),
    .we_i    (clr_we || cnt_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (mem_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  vehc_count_ram #(.DEPTH(vehc_pkg::SIDE_DEPTH), .WIDTH(CW)) u_side_ram (
    .clk_i   (clk_i),
    .we_i    (clr_we || cnt_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .re_i    (mem_re),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  always_comb begin
    rd_value = '0;
    if ({1'b0, rb_q} < (vehc_pkg::BIN_W + 1)'(vehc_pkg::NUM_BINS)) begin
      if (rc_q < vehc_pkg::RC_SL_BASE) begin
        rd_value = t_rdata;
      end else if (rc_q < vehc_pkg::RC_SIDE_BASE) begin
        rd_value = s_rdata;
      end else if (rc_q < vehc_pkg::RC_END) begin
        rd_value = d_rdata;
      end
    end
  end

  // Result word and output register.
  always_comb begin
    status_d = vehc_pkg::STAT_OK;
    bin_d    = '0;
    count_d  = '0;
    case (req_q)
      vehc_pkg::REQ_COUNT: begin
        if (lk_q.below) begin
          status_d = vehc_pkg::STAT_BELOW;
        end else if (lk_q.above) begin
          status_d = vehc_pkg::STAT_ABOVE;
        end else begin
          bin_d = 4'(lk_q.bin);
        end
      end
      vehc_pkg::REQ_READ: begin
        count_d = 32'(rd_value);
      end
      default: begin
        status_d = vehc_pkg::STAT_OK;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == vehc_pkg::ST_UPDATE && done) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign bin_index_o   = bin_q;
  assign count_value_o = count_q;

`ifndef ASSERT_OFF
  a_accept_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == vehc_pkg::ST_LOOKUP)
    else $error("accepted word did not enter lookup");

  a_update_after_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == vehc_pkg::ST_UPDATE |->
      $past(state_q) == vehc_pkg::ST_LOOKUP || $past(state_q) == vehc_pkg::ST_UPDATE)
    else $error("write-back entered without a counter read");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == vehc_pkg::ST_CLEAR |-> !in_accept && !cnt_we)
    else $error("word taken during the clearing pass");

  a_result_loaded_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vehc_pkg::ST_UPDATE && done) |=> state_q != vehc_pkg::ST_UPDATE)
    else $error("write-back repeated for one word");
`endif

endmodule

[dv/vehc_checker.sv]
// Checker that predicts histogram results from accepted request words and compares them.
`timescale 1ns / 1ps

module vehc_checker (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  input  logic                                    in_stall_i,
  input  logic [1:0]                              req_type_i,
  input  logic                                    edge_set_i,
  input  logic [vehc_pkg::EIDX_W-1:0]             edge_index_i,
  input  logic signed [vehc_pkg::VALUE_WIDTH-1:0] edge_value_i,
  input  logic signed [vehc_pkg::VALUE_WIDTH-1:0] sample_value_i,
  input  logic [vehc_pkg::TGT_W-1:0]              target_i,
  input  logic [vehc_pkg::RC_W-1:0]               read_counter_i,
  input  logic [vehc_pkg::BIN_W-1:0]              read_bin_i,
  input  logic                                    out_valid_i,
  input  logic                                    out_stall_i,
  input  logic [1:0]                              status_i,
  input  logic [vehc_pkg::BIN_W-1:0]              bin_index_i,
  input  logic [vehc_pkg::COUNT_WIDTH-1:0]        count_value_i,
  output int                                      fail_count_o,
  output int                                      pending_o
);

  typedef struct packed {
    logic [1:0]                       status;
    logic [vehc_pkg::BIN_W-1:0]       bin;
    logic [vehc_pkg::COUNT_WIDTH-1:0] value;
  } hist_word_t;

  logic signed [vehc_pkg::VALUE_WIDTH-1:0] edge_mem [2][vehc_pkg::NUM_EDGES];
  logic [vehc_pkg::COUNT_WIDTH-1:0]        target_cnt [vehc_pkg::TGT_DEPTH];
  logic [vehc_pkg::COUNT_WIDTH-1:0]        sideloc_cnt [vehc_pkg::SL_DEPTH];
  logic [vehc_pkg::COUNT_WIDTH-1:0]        side_cnt [vehc_pkg::SIDE_DEPTH];

  hist_word_t expected_q [$];
  hist_word_t want;
  int         mismatches;

  assign fail_count_o = mismatches;

  function automatic logic [vehc_pkg::COUNT_WIDTH-1:0] bumped(
    input logic [vehc_pkg::COUNT_WIDTH-1:0] c
  );
    return (&c) ? c : c + vehc_pkg::COUNT_WIDTH'(1);
  endfunction

  // Applies one request word to the shadow histogram and returns its result word.
  function automatic hist_word_t predict_word(
    input logic [1:0]                              req,
    input logic                                    set,
    input logic [vehc_pkg::EIDX_W-1:0]             eidx,
    input logic signed [vehc_pkg::VALUE_WIDTH-1:0] eval,
    input logic signed [vehc_pkg::VALUE_WIDTH-1:0] sample,
    input logic [vehc_pkg::TGT_W-1:0]              tgt,
    input logic [vehc_pkg::RC_W-1:0]               rc,
    input logic [vehc_pkg::BIN_W-1:0]              rb
  );
    hist_word_t r;
    logic       found;
    int         b;
    r = '0;
    found = 1'b0;
    b = 0;
    case (req)
      vehc_pkg::REQ_LOAD: begin
        if (eidx <= vehc_pkg::NUM_BINS) edge_mem[set][eidx] = eval;
      end
      vehc_pkg::REQ_COUNT: begin
        // The first edge that the sample does not exceed picks the bin.
        for (int i = 0; i < vehc_pkg::NUM_EDGES; i++) begin
          if (!found && sample <= edge_mem[set][i]) begin
            found = 1'b1;
            if (i == 0 && sample < edge_mem[set][i]) begin
              r.status = vehc_pkg::STAT_BELOW;
            end else begin
              b = (i == 0) ? 0 : i - 1;
              target_cnt[tgt * vehc_pkg::NUM_BINS + b] =
                bumped(target_cnt[tgt * vehc_pkg::NUM_BINS + b]);
              sideloc_cnt[(tgt >> 1) * vehc_pkg::NUM_BINS + b] =
                bumped(sideloc_cnt[(tgt >> 1) * vehc_pkg::NUM_BINS + b]);
              side_cnt[(tgt >> 2) * vehc_pkg::NUM_BINS + b] =
                bumped(side_cnt[(tgt >> 2) * vehc_pkg::NUM_BINS + b]);
              r.bin = b[vehc_pkg::BIN_W-1:0];
            end
          end
        end
        if (!found) r.status = vehc_pkg::STAT_ABOVE;
      end
      vehc_pkg::REQ_READ: begin
        if (rb < vehc_pkg::NUM_BINS) begin
          if (rc < vehc_pkg::RC_SL_BASE) begin
            r.value = target_cnt[rc * vehc_pkg::NUM_BINS + rb];
          end else if (rc < vehc_pkg::RC_SIDE_BASE) begin
            r.value = sideloc_cnt[(rc - vehc_pkg::RC_SL_BASE) * vehc_pkg::NUM_BINS + rb];
          end else if (rc < vehc_pkg::RC_END) begin
            r.value = side_cnt[(rc - vehc_pkg::RC_SIDE_BASE) * vehc_pkg::NUM_BINS + rb];
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < vehc_pkg::NUM_EDGES; i++) edge_mem[s][i] = '0;
      end
      for (int i = 0; i < vehc_pkg::TGT_DEPTH; i++) target_cnt[i] = '0;
      for (int i = 0; i < vehc_pkg::SL_DEPTH; i++) sideloc_cnt[i] = '0;
      for (int i = 0; i < vehc_pkg::SIDE_DEPTH; i++) side_cnt[i] = '0;
      expected_q.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      // A result always belongs to an older word, so it is checked before the new one is queued.
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result word with none expected: status %0d bin %0d count %0d",
                   $time, status_i, bin_index_i, count_value_i);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (status_i !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, status_i);
            mismatches++;
          end
          if (bin_index_i !== want.bin) begin
            $display("%0t: bin_index mismatch: expected %0d actual %0d",
                     $time, want.bin, bin_index_i);
            mismatches++;
          end
          if (count_value_i !== want.value) begin
            $display("%0t: count_value mismatch: expected %0d actual %0d",
                     $time, want.value, count_value_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.insert(expected_q.size(),
                          predict_word(req_type_i, edge_set_i, edge_index_i, edge_value_i,
                                       sample_value_i, target_i, read_counter_i,
                                       read_bin_i));
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

[dv/tb.sv]
// Testbench top that drives request words into the histogram counter and reports the verdict.
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_WORDS = 1900;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic signed [vehc_pkg::VALUE_WIDTH-1:0] VAL_MAX = 32'sh7FFFFFFF;
  localparam logic signed [vehc_pkg::VALUE_WIDTH-1:0] VAL_MIN = 32'sh80000000;

  logic                                    clk;
  logic                                    rst_n = 1'b0;
  logic                                    in_valid = 1'b0;
  logic                                    in_stall;
  logic [1:0]                              req_type = '0;
  logic                                    edge_set = 1'b0;
  logic [vehc_pkg::EIDX_W-1:0]             edge_index = '0;
  logic signed [vehc_pkg::VALUE_WIDTH-1:0] edge_value = '0;
  logic signed [vehc_pkg::VALUE_WIDTH-1:0] sample_value = '0;
  logic [vehc_pkg::TGT_W-1:0]              target = '0;
  logic [vehc_pkg::RC_W-1:0]               read_counter = '0;
  logic [vehc_pkg::BIN_W-1:0]              read_bin = '0;
  logic                                    out_valid;
  logic                                    out_stall = 1'b0;
  logic [1:0]                              status;
  logic [vehc_pkg::BIN_W-1:0]              bin_index;
  logic [vehc_pkg::COUNT_WIDTH-1:0]        count_value;

  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   words_sent = 0;
  logic calm = 1'b0;

  // Edges as loaded so far, used only to aim samples at and between the edges.
  logic signed [vehc_pkg::VALUE_WIDTH-1:0] edge_shadow [2][vehc_pkg::NUM_EDGES];

  variable_edge_histogram_counter dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .req_type_i    (req_type),
    .edge_set_i    (edge_set),
    .edge_index_i  (edge_index),
    .edge_value_i  (edge_value),
    .sample_value_i(sample_value),
    .target_i      (target),
    .read_counter_i(read_counter),
    .read_bin_i    (read_bin),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .bin_index_o   (bin_index),
    .count_value_o (count_value)
  );

  vehc_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .req_type_i    (req_type),
    .edge_set_i    (edge_set),
    .edge_index_i  (edge_index),
    .edge_value_i  (edge_value),
    .sample_value_i(sample_value),
    .target_i      (target),
    .read_counter_i(read_counter),
    .read_bin_i    (read_bin),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .status_i      (status),
    .bin_index_i   (bin_index),
    .count_value_i (count_value),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("variable_edge_histogram_counter test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 20);
  end

  // Presents one word and returns at the edge that accepts it; valid stays high.
  task automatic send_word(input vehc_pkg::req_e req, input logic set,
                           input logic [vehc_pkg::EIDX_W-1:0] eidx,
                           input logic signed [vehc_pkg::VALUE_WIDTH-1:0] eval,
                           input logic signed [vehc_pkg::VALUE_WIDTH-1:0] sample,
                           input logic [vehc_pkg::TGT_W-1:0] tgt,
                           input logic [vehc_pkg::RC_W-1:0] rc,
                           input logic [vehc_pkg::BIN_W-1:0] rb);
    req_type     <= req;
    edge_set     <= set;
    edge_index   <= eidx;
    edge_value   <= eval;
    sample_value <= sample;
    target       <= tgt;
    read_counter <= rc;
    read_bin     <= rb;
    in_valid     <= 1'b1;
    if (req == vehc_pkg::REQ_LOAD && eidx <= vehc_pkg::NUM_BINS) edge_shadow[set][eidx] = eval;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Loads a whole edge set in ascending order: wide spread, narrow with repeats,
  // or wide starting at the most negative value.
  task automatic load_edge_set(input logic set, input int mode);
    longint                                  e;
    logic signed [vehc_pkg::VALUE_WIDTH-1:0] start;
    int unsigned                             step_max;
    start = vehc_pkg::VALUE_WIDTH'($urandom);
    e = (mode == 2) ? longint'(VAL_MIN) : longint'(start);
    step_max = (mode == 1) ? 3 : (32'd1 << 28);
    for (int k = 0; k < vehc_pkg::NUM_EDGES; k++) begin
      if (e > longint'(VAL_MAX)) e = longint'(VAL_MAX);
      maybe_idle();
      send_word(vehc_pkg::REQ_LOAD, set, k[vehc_pkg::EIDX_W-1:0],
                e[vehc_pkg::VALUE_WIDTH-1:0], vehc_pkg::VALUE_WIDTH'($urandom),
                vehc_pkg::TGT_W'($urandom), vehc_pkg::RC_W'($urandom),
                vehc_pkg::BIN_W'($urandom));
      e += longint'($urandom_range(0, step_max));
    end
  endtask

  task automatic send_random_word();
    vehc_pkg::req_e                          req;
    logic                                    set;
    logic [vehc_pkg::EIDX_W-1:0]             eidx;
    logic signed [vehc_pkg::VALUE_WIDTH-1:0] eval;
    logic signed [vehc_pkg::VALUE_WIDTH-1:0] sample;
    logic [vehc_pkg::TGT_W-1:0]              tgt;
    logic [vehc_pkg::RC_W-1:0]               rc;
    logic [vehc_pkg::BIN_W-1:0]              rb;
    int                                      pick;
    int                                      i;
    int                                      delta;
    longint                                  lo;
    longint                                  span;
    set    = 1'($urandom);
    eidx   = vehc_pkg::EIDX_W'($urandom);
    eval   = vehc_pkg::VALUE_WIDTH'($urandom);
    sample = vehc_pkg::VALUE_WIDTH'($urandom);
    tgt    = vehc_pkg::TGT_W'($urandom);
    rc     = vehc_pkg::RC_W'($urandom);
    rb     = vehc_pkg::BIN_W'($urandom);
    pick   = $urandom_range(0, 99);
    if (pick < 8) begin
      req = vehc_pkg::REQ_LOAD;
      if ($urandom_range(0, 3) != 0) begin
        eidx = vehc_pkg::EIDX_W'($urandom_range(0, vehc_pkg::NUM_BINS));
      end
    end else if (pick < 62) begin
      req = vehc_pkg::REQ_COUNT;
      i = $urandom_range(0, vehc_pkg::NUM_BINS);
      case ($urandom_range(0, 3))
        1: begin
          delta = $urandom_range(0, 2);
          sample = edge_shadow[set][i] + vehc_pkg::VALUE_WIDTH'(delta - 1);
        end
        2: begin
          lo = longint'(edge_shadow[set][0]);
          span = longint'(edge_shadow[set][vehc_pkg::NUM_BINS]) - lo;
          if (span > 0) begin
            lo = lo + (longint'($urandom) % (span + 1));
            sample = lo[vehc_pkg::VALUE_WIDTH-1:0];
          end
        end
        3: sample = ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
        default: begin
        end
      endcase
    end else if (pick < 95) begin
      req = vehc_pkg::REQ_READ;
    end else begin
      req = vehc_pkg::REQ_NONE;
    end
    send_word(req, set, eidx, eval, sample, tgt, rc, rb);
  endtask

  initial begin
    int iter;
    int goal;
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < vehc_pkg::NUM_EDGES; k++) edge_shadow[s][k] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Fresh counters read zero, including unused selectors.
    send_word(vehc_pkg::REQ_READ, 1'b0, '0, '0, '0, '0, 4'd0, 4'd0);
    send_word(vehc_pkg::REQ_READ, 1'b1, '0, '0, '0, '0, 4'd14, 4'd3);
    send_word(vehc_pkg::REQ_READ, 1'b0, '1, '1, '1, '1, 4'd15, 4'd15);
    send_word(vehc_pkg::REQ_NONE, 1'b1, '1, '1, '1, '1, '1, '1);
    // All edges zero: equal to the lowest edge, below it, above all.
    send_word(vehc_pkg::REQ_COUNT, 1'b0, '0, '0, 32'sd0, 3'd0, '0, '0);
    send_word(vehc_pkg::REQ_COUNT, 1'b0, '0, '0, -32'sd1, 3'd1, '0, '0);
    send_word(vehc_pkg::REQ_COUNT, 1'b1, '0, '0, 32'sd1, 3'd4, '0, '0);
    send_word(vehc_pkg::REQ_COUNT, 1'b1, '0, '0, VAL_MIN, 3'd3, '0, '0);
    send_word(vehc_pkg::REQ_COUNT, 1'b0, '0, '0, VAL_MAX, 3'd6, '0, '0);
    // Loads past the last edge are dropped; then edges 16 and 0 of set 0 take the extremes.
    send_word(vehc_pkg::REQ_LOAD, 1'b0, 5'd17, 32'sd5, '0, '0, '0, '0);
    send_word(vehc_pkg::REQ_LOAD, 1'b1, 5'd31, VAL_MIN, '1, '1, '1, '1);
    send_word(vehc_pkg::REQ_LOAD, 1'b0, 5'd16, VAL_MAX, '0, '0, '0, '0);
    send_word(vehc_pkg::REQ_LOAD, 1'b0, 5'd0, VAL_MIN, '0, '0, '0, '0);
    send_word(vehc_pkg::REQ_COUNT, 1'b0, '0, '0, VAL_MAX, 3'd7, '0, '0);
    send_word(vehc_pkg::REQ_COUNT, 1'b0, '0, '0, VAL_MIN, 3'd5, '0, '0);
    // Location bit of the target disagrees with the edge set here.
    send_word(vehc_pkg::REQ_COUNT, 1'b0, '0, '0, -32'sd5, 3'd2, '0, '0);
    send_word(vehc_pkg::REQ_COUNT, 1'b1, '0, '0, 32'sd0, 3'd2, '0, '0);
    send_word(vehc_pkg::REQ_COUNT, 1'b0, '0, '0, 32'sd7, 3'd7, '0, '0);
    send_word(vehc_pkg::REQ_READ, 1'b0, '0, '0, '0, '0, 4'd0, 4'd0);
    send_word(vehc_pkg::REQ_READ, 1'b0, '0, '0, '0, '0, 4'd7, 4'd15);
    send_word(vehc_pkg::REQ_READ, 1'b0, '0, '0, '0, '0, 4'd2, 4'd0);
    send_word(vehc_pkg::REQ_READ, 1'b0, '0, '0, '0, '0, 4'd9, 4'd0);
    send_word(vehc_pkg::REQ_READ, 1'b0, '0, '0, '0, '0, 4'd11, 4'd15);
    send_word(vehc_pkg::REQ_READ, 1'b0, '0, '0, '0, '0, 4'd12, 4'd0);
    send_word(vehc_pkg::REQ_READ, 1'b0, '0, '0, '0, '0, 4'd13, 4'd15);
    wait_drained();

    iter = 0;
    goal = words_sent + RANDOM_WORDS;
    while (words_sent < goal) begin
      calm <= (iter >= 700 && iter < 1000);
      if (iter % 120 == 0) begin
        load_edge_set(1'($urandom), $urandom_range(0, 2));
      end else begin
        if (iter == 600) wait_drained();
        else maybe_idle();
        send_random_word();
      end
      iter++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("variable_edge_histogram_counter test passed");
    end else begin
      $display("variable_edge_histogram_counter test failed");
    end
    $finish;
  end

endmodule
